### hdl/ufx_pkg.sv
// Shared types, constants and pointer helpers for the UART FIFO block.
package ufx_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_IDX_W = $clog2(RX_DEPTH);
   localparam int TX_IDX_W = $clog2(TX_DEPTH);
   localparam int RX_PTR_W = RX_IDX_W + 1;
   localparam int TX_PTR_W = TX_IDX_W + 1;

   localparam int LVL_W    = 7;
   localparam int WM_W     = 7;
   localparam int CNT_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam int RSP_W    = 72;

   localparam logic [BYTE_W-1:0] CHAR_XON  = 8'h11;
   localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'h13;
   localparam logic [WM_W-1:0]   WM_RESET  = 7'd32;

   typedef enum logic [2:0] {
      CMD_RX_BYTE  = 3'd0,
      CMD_IDLE     = 3'd1,
      CMD_OVERRUN  = 3'd2,
      CMD_TX_READY = 3'd3,
      CMD_TX_DONE  = 3'd4,
      CMD_HOST_WR  = 3'd5,
      CMD_HOST_RD  = 3'd6,
      CMD_TX_RESET = 3'd7
   } cmd_code_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FLOW_XONXOFF = 1'd0,
      CSR_RX_WATERMARK = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_full;
   } ctrl_status_type;

   // lowest bits last: read_byte sits at bit 0
   typedef struct packed {
      logic [2:0]        pad;
      logic              tx_paused;
      logic [CNT_W-1:0]  error_count;
      logic [LVL_W-1:0]  tx_level;
      logic [LVL_W-1:0]  rx_level;
      logic              driver_enable;
      logic              tx_space_open;
      logic              rx_notify;
      logic              write_accepted;
      logic              line_valid;
      logic [BYTE_W-1:0] line_byte;
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
   } rsp_type;

   function automatic logic [RX_PTR_W-1:0] rx_ptr_next(input logic [RX_PTR_W-1:0] p);
      logic [RX_PTR_W:0] top;
      top = (RX_PTR_W+1)'(2 * RX_DEPTH - 1);
      return ({1'b0, p} == top) ? '0 : RX_PTR_W'({1'b0, p} + 1'b1);
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_ptr_next(input logic [TX_PTR_W-1:0] p);
      logic [TX_PTR_W:0] top;
      top = (TX_PTR_W+1)'(2 * TX_DEPTH - 1);
      return ({1'b0, p} == top) ? '0 : TX_PTR_W'({1'b0, p} + 1'b1);
   endfunction

   function automatic logic [RX_IDX_W-1:0] rx_ptr_idx(input logic [RX_PTR_W-1:0] p);
      logic [RX_PTR_W-1:0] d;
      d = RX_PTR_W'(RX_DEPTH);
      return (p >= d) ? RX_IDX_W'(p - d) : RX_IDX_W'(p);
   endfunction

   function automatic logic [TX_IDX_W-1:0] tx_ptr_idx(input logic [TX_PTR_W-1:0] p);
      logic [TX_PTR_W-1:0] d;
      d = TX_PTR_W'(TX_DEPTH);
      return (p >= d) ? TX_IDX_W'(p - d) : TX_IDX_W'(p);
   endfunction

   function automatic logic [RX_PTR_W-1:0] rx_ptr_level(input logic [RX_PTR_W-1:0] wr,
                                                        input logic [RX_PTR_W-1:0] rd);
      logic [RX_PTR_W:0] wrap;
      wrap = {1'b0, wr} + (RX_PTR_W+1)'(2 * RX_DEPTH) - {1'b0, rd};
      return (wr >= rd) ? RX_PTR_W'(wr - rd) : RX_PTR_W'(wrap);
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_ptr_level(input logic [TX_PTR_W-1:0] wr,
                                                        input logic [TX_PTR_W-1:0] rd);
      logic [TX_PTR_W:0] wrap;
      wrap = {1'b0, wr} + (TX_PTR_W+1)'(2 * TX_DEPTH) - {1'b0, rd};
      return (wr >= rd) ? TX_PTR_W'(wr - rd) : TX_PTR_W'(wrap);
   endfunction

endpackage

### hdl/uart_fifo_xonxoff_rs485.sv
// Top level of the UART FIFO block with XON/XOFF flow control and RS485 direction.
//
// Each transfer on the request side carries one event (received byte, line idle,
// overrun, transmitter ready, transmission complete, host write, host read or
// transmit reset) and yields exactly one status transfer on the response side.
// An event is handled in two steps: capture, which registers it and reads the head
// of both 64-byte FIFO memories into registers, then execute, which loads the result
// register. A new event is accepted only after the previous one has executed, and
// only while the result register is empty or being drained in that cycle.
// Configuration writes are registered and are expected only while no event is in flight.
module uart_fifo_xonxoff_rs485 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data
   input  logic [2:0]                      req_tuser,  // command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_byte, read_valid, line_byte, line_valid, write_accepted, rx_notify,
   // tx_space_open, driver_enable, rx_level, tx_level, error_count, tx_paused
   output logic [ufx_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_we,
   input  logic [ufx_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ufx_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ufx_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   rsp_type         rsp_out;

   ufx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ufx_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_command (req_tuser),
      .req_data    (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_out     (rsp_out),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   assign rsp_tdata = RSP_W'(rsp_out);

endmodule

### hdl/ufx_ctrl.sv
// Controller state machine: sequences capture and execute of each event.
module ufx_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     rsp_tready,
   input  ufx_pkg::ctrl_status_type status,
   output ufx_pkg::ctrl_cmd_type    cmd
);
   import ufx_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && (!status.out_full || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmd.capture = accept;
   assign cmd.exec    = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("capture not followed by execute");

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !req_tready)
      else $error("input ready during execute");

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("execute held longer than one cycle");

endmodule

### hdl/ufx_datapath.sv
// Datapath: receive and transmit FIFOs, flow and direction flags, result register.
module ufx_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ufx_pkg::ctrl_cmd_type           cmd,
   output ufx_pkg::ctrl_status_type        status,
   input  logic [2:0]                      req_command,
   input  logic [ufx_pkg::BYTE_W-1:0]      req_data,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output ufx_pkg::rsp_type                rsp_out,
   input  logic                            csr_we,
   input  logic [ufx_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ufx_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ufx_pkg::*;

   logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
   logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

   cmd_code_type      cmd_ff;
   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] rx_rd_data_ff, tx_rd_data_ff;

   logic [RX_PTR_W-1:0] rx_wr_ptr_ff, rx_wr_ptr_in, rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [TX_PTR_W-1:0] tx_wr_ptr_ff, tx_wr_ptr_in, tx_rd_ptr_ff, tx_rd_ptr_in;
   logic flow_on_ff, flow_on_in;
   logic ready_irq_en_ff, ready_irq_en_in;
   logic complete_irq_en_ff, complete_irq_en_in;
   logic drive_ff, drive_in;
   logic [CNT_W-1:0] overrun_ff, overrun_in;
   logic flow_xonxoff_ff, flow_xonxoff_in;
   logic [WM_W-1:0] rx_watermark_ff, rx_watermark_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic rx_we, tx_we;
   logic [RX_PTR_W-1:0] rx_lvl_now;
   logic [TX_PTR_W-1:0] tx_lvl_now;

   always_comb begin
      rx_wr_ptr_in       = rx_wr_ptr_ff;
      rx_rd_ptr_in       = rx_rd_ptr_ff;
      tx_wr_ptr_in       = tx_wr_ptr_ff;
      tx_rd_ptr_in       = tx_rd_ptr_ff;
      flow_on_in         = flow_on_ff;
      ready_irq_en_in    = ready_irq_en_ff;
      complete_irq_en_in = complete_irq_en_ff;
      drive_in           = drive_ff;
      overrun_in         = overrun_ff;
      flow_xonxoff_in    = flow_xonxoff_ff;
      rx_watermark_in    = rx_watermark_ff;
      rx_we              = 1'b0;
      tx_we              = 1'b0;
      out_in             = '0;
      rx_lvl_now         = rx_ptr_level(rx_wr_ptr_ff, rx_rd_ptr_ff);
      tx_lvl_now         = tx_ptr_level(tx_wr_ptr_ff, tx_rd_ptr_ff);

      if (cmd.exec) begin
         case (cmd_ff)
            CMD_RX_BYTE: begin
               if (flow_xonxoff_ff && data_ff == CHAR_XON) begin
                  if (!flow_on_ff) begin
                     flow_on_in      = 1'b1;
                     ready_irq_en_in = 1'b1;
                  end
               end else if (flow_xonxoff_ff && data_ff == CHAR_XOFF) begin
                  flow_on_in = 1'b0;
               end else begin
                  if (rx_lvl_now < RX_PTR_W'(RX_DEPTH)) begin
                     rx_we        = 1'b1;
                     rx_wr_ptr_in = rx_ptr_next(rx_wr_ptr_ff);
                  end
                  out_in.rx_notify = (32'(rx_lvl_now) > 32'(rx_watermark_ff));
               end
            end
            CMD_IDLE: begin
               out_in.rx_notify = 1'b1;
            end
            CMD_OVERRUN: begin
               overrun_in = overrun_ff + 1'b1;
            end
            CMD_TX_READY: begin
               if (ready_irq_en_ff) begin
                  if (tx_rd_ptr_ff == tx_wr_ptr_ff || !flow_on_ff) begin
                     ready_irq_en_in      = 1'b0;
                     complete_irq_en_in   = 1'b1;
                     out_in.tx_space_open = 1'b1;
                  end else begin
                     drive_in          = 1'b1;
                     out_in.line_byte  = tx_rd_data_ff;
                     out_in.line_valid = 1'b1;
                     tx_rd_ptr_in      = tx_ptr_next(tx_rd_ptr_ff);
                  end
               end
            end
            CMD_TX_DONE: begin
               if (complete_irq_en_ff) begin
                  drive_in           = 1'b0;
                  complete_irq_en_in = 1'b0;
               end
            end
            CMD_HOST_WR: begin
               if (tx_lvl_now < TX_PTR_W'(TX_DEPTH)) begin
                  tx_we                 = 1'b1;
                  tx_wr_ptr_in          = tx_ptr_next(tx_wr_ptr_ff);
                  out_in.write_accepted = 1'b1;
               end
               ready_irq_en_in = 1'b1;
            end
            CMD_HOST_RD: begin
               if (rx_rd_ptr_ff != rx_wr_ptr_ff) begin
                  out_in.read_byte  = rx_rd_data_ff;
                  out_in.read_valid = 1'b1;
                  rx_rd_ptr_in      = rx_ptr_next(rx_rd_ptr_ff);
               end
            end
            default: begin
               tx_wr_ptr_in = '0;
               tx_rd_ptr_in = '0;
            end
         endcase
      end

      out_in.driver_enable = drive_in;
      out_in.rx_level      = LVL_W'(rx_ptr_level(rx_wr_ptr_in, rx_rd_ptr_in));
      out_in.tx_level      = LVL_W'(tx_ptr_level(tx_wr_ptr_in, tx_rd_ptr_in));
      out_in.error_count   = overrun_in;
      out_in.tx_paused     = !flow_on_in;

      // the user must write configuration only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_addr)
            CSR_FLOW_XONXOFF: begin
               if (!csr_wdata[0] && flow_xonxoff_ff) begin
                  flow_xonxoff_in = 1'b0;
                  if (!flow_on_ff) begin
                     flow_on_in      = 1'b1;
                     ready_irq_en_in = 1'b1;
                  end
               end else if (csr_wdata[0] && !flow_xonxoff_ff) begin
                  flow_xonxoff_in = 1'b1;
                  flow_on_in      = 1'b1;
               end
            end
            CSR_RX_WATERMARK: begin
               rx_watermark_in = csr_wdata;
            end
            default: begin
               rx_watermark_in = rx_watermark_ff;
            end
         endcase
      end

      if (cmd.exec) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ptr_ff       <= '0;
         rx_rd_ptr_ff       <= '0;
         tx_wr_ptr_ff       <= '0;
         tx_rd_ptr_ff       <= '0;
         flow_on_ff         <= 1'b1;
         ready_irq_en_ff    <= 1'b0;
         complete_irq_en_ff <= 1'b0;
         drive_ff           <= 1'b0;
         overrun_ff         <= '0;
         flow_xonxoff_ff    <= 1'b0;
         rx_watermark_ff    <= WM_RESET;
         out_valid_ff       <= 1'b0;
      end else begin
         rx_wr_ptr_ff       <= rx_wr_ptr_in;
         rx_rd_ptr_ff       <= rx_rd_ptr_in;
         tx_wr_ptr_ff       <= tx_wr_ptr_in;
         tx_rd_ptr_ff       <= tx_rd_ptr_in;
         flow_on_ff         <= flow_on_in;
         ready_irq_en_ff    <= ready_irq_en_in;
         complete_irq_en_ff <= complete_irq_en_in;
         drive_ff           <= drive_in;
         overrun_ff         <= overrun_in;
         flow_xonxoff_ff    <= flow_xonxoff_in;
         rx_watermark_ff    <= rx_watermark_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= cmd_code_type'(req_command);
         data_ff <= req_data;
      end
      if (cmd.exec) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_ptr_idx(rx_wr_ptr_ff)] <= data_ff;
      end
      if (cmd.capture) begin
         rx_rd_data_ff <= rx_mem[rx_ptr_idx(rx_rd_ptr_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_ptr_idx(tx_wr_ptr_ff)] <= data_ff;
      end
      if (cmd.capture) begin
         tx_rd_data_ff <= tx_mem[tx_ptr_idx(tx_rd_ptr_ff)];
      end
   end

   assign status.out_full = out_valid_ff;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_out         = out_ff;

   a_rx_level_bound: assert property (@(posedge clock) disable iff (reset)
      rx_ptr_level(rx_wr_ptr_ff, rx_rd_ptr_ff) <= RX_PTR_W'(RX_DEPTH))
      else $error("receive FIFO level above depth");

   a_exec_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> out_valid_ff)
      else $error("execute did not load result");

   a_overrun_count: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd_ff == CMD_OVERRUN && !csr_we |=> overrun_ff == $past(overrun_ff) + 1'b1)
      else $error("overrun count not advanced");

   a_line_needs_enable: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && out_in.line_valid |-> ready_irq_en_ff && flow_on_ff)
      else $error("byte sent while transmitter not enabled");

endmodule
